[src/sem_pkg.sv]
// ---------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ---------------------------------------------------------------------------
package sem_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 2048;

	localparam int PIX_W        = 8;
	localparam int FW_W         = 12;
	localparam int FH_W         = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int GRAD_W       = 11;
	localparam int ROOT_W       = 2 * GRAD_W;
	localparam int ROOT_TOP     = 20;
	localparam int MIN_DIM      = 3;
	localparam int FIRST_INNER  = 2;
	localparam int OUT_MAX      = 255;
	localparam int Q_DEPTH      = 2;
	localparam int Q_PTR_W      = 1;
	localparam int Q_CNT_W      = 2;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic                     last;
	} grad_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQUARE,
		BK_SUM,
		BK_ROOT,
		BK_DONE
	} back_state_t;

endpackage

[src/sem_front.sv]
// ---------------------------------------------------------------------------
// sem_front
// Pixel intake: raster position, line store, 3x3 window and Sobel sums.
// ---------------------------------------------------------------------------
module sem_front #(
	parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [sem_pkg::FW_W-1:0]          frame_width,
	input  logic [sem_pkg::FH_W-1:0]          frame_height,
	input  logic                              push,
	output logic                              full,
	input  logic [sem_pkg::PIX_W-1:0]         pixel_in,
	output logic                              q_push,
	output sem_pkg::grad_t                    q_data,
	input  logic                              q_full
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = (AW + 1 > sem_pkg::FW_W) ? AW + 1 : sem_pkg::FW_W;
	localparam int PW = sem_pkg::PIX_W;
	localparam int SW = PW + 2;

	logic [CW-1:0]            w_raw;
	logic [CW-1:0]            w_eff;
	logic [sem_pkg::FH_W-1:0] h_eff;
	logic [AW-1:0]            col_q;
	logic [sem_pkg::FH_W-1:0] row_q;
	logic [CW-1:0]            col_ext;
	logic [CW-1:0]            col_nxt;
	logic [sem_pkg::FH_W:0]   row_nxt;
	logic                     col_wrap;
	logic                     row_wrap;
	logic                     emit;
	logic                     last;
	logic                     accept;

	logic [2*PW-1:0]          line_mem [MAX_WIDTH];
	logic [2*PW-1:0]          rd_q;

	logic                     valid_s1;
	logic                     emit_s1;
	logic                     last_s1;
	logic [AW-1:0]            col_s1;
	logic [PW-1:0]            px_s1;
	logic                     adv_s1;

	logic [PW-1:0]            win_l_q [3];
	logic [PW-1:0]            win_m_q [3];
	logic [PW-1:0]            new_col [3];
	logic [SW-1:0]            sum_l;
	logic [SW-1:0]            sum_r;
	logic [SW-1:0]            sum_t;
	logic [SW-1:0]            sum_b;

	always_comb begin
		w_raw = CW'(frame_width);
		w_eff = w_raw;
		if (w_raw < CW'(sem_pkg::MIN_DIM)) begin
			w_eff = CW'(sem_pkg::MIN_DIM);
		end else if (w_raw > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end
		h_eff = (frame_height < sem_pkg::FH_W'(sem_pkg::MIN_DIM)) ?
			sem_pkg::FH_W'(sem_pkg::MIN_DIM) : frame_height;
	end

	assign col_ext  = CW'(col_q);
	assign col_nxt  = col_ext + CW'(1);
	assign row_nxt  = (sem_pkg::FH_W + 1)'(row_q) + (sem_pkg::FH_W + 1)'(1);
	assign col_wrap = col_nxt >= w_eff;
	assign row_wrap = row_nxt >= (sem_pkg::FH_W + 1)'(h_eff);
	assign emit     = (row_q >= sem_pkg::FH_W'(sem_pkg::FIRST_INNER)) &&
		(col_ext >= CW'(sem_pkg::FIRST_INNER)) && (row_q < h_eff) && (col_ext < w_eff);
	assign last     = (row_q == h_eff - sem_pkg::FH_W'(1)) && (col_ext == w_eff - CW'(1));

	assign adv_s1 = valid_s1 && (!emit_s1 || !q_full);
	assign full   = valid_s1 && !adv_s1;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_nxt[sem_pkg::FH_W-1:0];
			end else begin
				col_q <= col_nxt[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[col_s1] <= {rd_q[PW-1:0], px_s1};
		end
		if (accept) begin
			rd_q <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit;
			last_s1 <= last;
			col_s1  <= col_q;
			px_s1   <= pixel_in;
		end
	end

	assign new_col[0] = rd_q[2*PW-1:PW];
	assign new_col[1] = rd_q[PW-1:0];
	assign new_col[2] = px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_l_q[i] <= '0;
				win_m_q[i] <= '0;
			end
		end else if (adv_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_l_q[i] <= win_m_q[i];
				win_m_q[i] <= new_col[i];
			end
		end
	end

	always_comb begin
		sum_l = SW'(win_l_q[0]) + {1'b0, win_l_q[1], 1'b0} + SW'(win_l_q[2]);
		sum_r = SW'(new_col[0]) + {1'b0, new_col[1], 1'b0} + SW'(new_col[2]);
		sum_t = SW'(win_l_q[0]) + {1'b0, win_m_q[0], 1'b0} + SW'(new_col[0]);
		sum_b = SW'(win_l_q[2]) + {1'b0, win_m_q[2], 1'b0} + SW'(new_col[2]);
		q_data.gx   = signed'({1'b0, sum_r}) - signed'({1'b0, sum_l});
		q_data.gy   = signed'({1'b0, sum_b}) - signed'({1'b0, sum_t});
		q_data.last = last_s1;
	end

	assign q_push = adv_s1 && emit_s1;

`ifndef SYNTHESIS
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && valid_s1) |-> (col_q != col_s1))
		else $error("line store read and write collide");
`endif

endmodule

[src/sem_fifo.sv]
// ---------------------------------------------------------------------------
// sem_fifo
// Short queue of gradient pairs between the pixel intake and the root unit.
// ---------------------------------------------------------------------------
module sem_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  sem_pkg::grad_t wr_data,
	output logic           q_full,
	input  logic           rd,
	output sem_pkg::grad_t rd_data,
	output logic           q_empty
);

	sem_pkg::grad_t                 entry_q [sem_pkg::Q_DEPTH];
	logic [sem_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [sem_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [sem_pkg::Q_CNT_W-1:0]    count_q;

	assign q_full  = count_q == sem_pkg::Q_CNT_W'(sem_pkg::Q_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + sem_pkg::Q_PTR_W'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + sem_pkg::Q_PTR_W'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + sem_pkg::Q_CNT_W'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - sem_pkg::Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && q_full))
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd && q_empty))
		else $error("queue read while empty");
`endif

endmodule

[src/sem_back.sv]
// ---------------------------------------------------------------------------
// sem_back
// Root unit: squares, exact integer square root with rounding, result register.
// ---------------------------------------------------------------------------
module sem_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  sem_pkg::grad_t            q_data,
	output logic                      q_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic [sem_pkg::PIX_W-1:0] edge_value,
	output logic                      frame_last
);

	localparam int RW = sem_pkg::ROOT_W;

	sem_pkg::back_state_t             state_q;
	sem_pkg::back_state_t             state_d;

	logic signed [sem_pkg::GRAD_W-1:0] gx_q;
	logic signed [sem_pkg::GRAD_W-1:0] gy_q;
	logic                              last_q;
	logic signed [RW-1:0]              sqx_w;
	logic signed [RW-1:0]              sqy_w;
	logic [RW-1:0]                     sqx_q;
	logic [RW-1:0]                     sqy_q;
	logic [RW-1:0]                     rem_q;
	logic [RW-1:0]                     res_q;
	logic [RW-1:0]                     bit_q;
	logic [RW-1:0]                     trial;
	logic [RW-1:0]                     rounded;
	logic                              can_load;
	logic                              load_out;
	logic                              out_valid_q;
	logic [sem_pkg::PIX_W-1:0]         edge_q;
	logic                              flag_q;

	assign can_load = !out_valid_q || pop;

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			sem_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = sem_pkg::BK_SQUARE;
				end
			end
			sem_pkg::BK_SQUARE: begin
				state_d = sem_pkg::BK_SUM;
			end
			sem_pkg::BK_SUM: begin
				state_d = sem_pkg::BK_ROOT;
			end
			sem_pkg::BK_ROOT: begin
				if ((bit_q >> 2) == '0) begin
					state_d = sem_pkg::BK_DONE;
				end
			end
			sem_pkg::BK_DONE: begin
				if (can_load) begin
					load_out = 1'b1;
					state_d  = sem_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = sem_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sem_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign sqx_w   = RW'(gx_q) * RW'(gx_q);
	assign sqy_w   = RW'(gy_q) * RW'(gy_q);
	assign trial   = res_q + bit_q;
	assign rounded = (rem_q > res_q) ? res_q + RW'(1) : res_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			gx_q   <= q_data.gx;
			gy_q   <= q_data.gy;
			last_q <= q_data.last;
		end
		if (state_q == sem_pkg::BK_SQUARE) begin
			sqx_q <= $unsigned(sqx_w);
			sqy_q <= $unsigned(sqy_w);
		end
		if (state_q == sem_pkg::BK_SUM) begin
			rem_q <= sqx_q + sqy_q;
			res_q <= '0;
			bit_q <= RW'(1) << sem_pkg::ROOT_TOP;
		end else if (state_q == sem_pkg::BK_ROOT) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (load_out) begin
			edge_q <= (rounded > RW'(sem_pkg::OUT_MAX)) ?
				sem_pkg::PIX_W'(sem_pkg::OUT_MAX) : rounded[sem_pkg::PIX_W-1:0];
			flag_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty      = !out_valid_q;
	assign edge_value = edge_q;
	assign frame_last = flag_q;

`ifndef SYNTHESIS
	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sem_pkg::BK_ROOT) |-> $onehot(bit_q))
		else $error("root step weight is not a single bit");
`endif

endmodule

[src/sobel_edge_magnitude.sv]
// ---------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel gradient magnitude over raster-order grayscale pixels.
//
// Channel   Handshake              Payload
// input     push / full            pixel_in
// result    empty / pop            edge_value, frame_last
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The intake takes one pixel per cycle while the gradient queue has room.
// Each interior pixel passes through the root unit's steps in order: queue pop,
// squaring, sum, 11 square-root steps and the load of the result register.
// Border pixels produce no result.
// Reset clears positions, window and handshake state; the line store needs
// no clearing pass. cfg_ready is always high.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude #(
	parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [sem_pkg::PIX_W-1:0]       pixel_in,
	output logic                            empty,
	input  logic                            pop,
	output logic [sem_pkg::PIX_W-1:0]       edge_value,
	output logic                            frame_last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [sem_pkg::FW_W-1:0] frame_width_q;
	logic [sem_pkg::FH_W-1:0] frame_height_q;
	logic                     q_wr;
	sem_pkg::grad_t           q_wr_data;
	logic                     q_full;
	logic                     q_rd;
	sem_pkg::grad_t           q_rd_data;
	logic                     q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sem_pkg::FRAME_WIDTH_RST;
			frame_height_q <= sem_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sem_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[sem_pkg::FW_W-1:0];
				end
				sem_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[sem_pkg::FH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sem_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.push        (push),
		.full        (full),
		.pixel_in    (pixel_in),
		.q_push      (q_wr),
		.q_data      (q_wr_data),
		.q_full      (q_full)
	);

	sem_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_data(q_wr_data),
		.q_full (q_full),
		.rd     (q_rd),
		.rd_data(q_rd_data),
		.q_empty(q_empty)
	);

	sem_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rd_data),
		.q_pop     (q_rd),
		.empty     (empty),
		.pop       (pop),
		.edge_value(edge_value),
		.frame_last(frame_last)
	);

endmodule
